// File: rtl/sfir_pkg.sv
package sfir_pkg;

	localparam int SAMPLE_BITS     = 16;
	localparam int COEF_BITS       = 16;
	localparam int COEF_INDEX_BITS = 5;
	localparam int TAP_COUNT_BITS  = 6;
	localparam int STRIDE_BITS     = 5;
	localparam int CFG_DATA_BITS   = 6;
	localparam int CFG_INDEX_BITS  = 1;
	localparam int FRAC_SHIFT      = 15;

	localparam int MAX_TAPS_DEF      = 32;
	localparam int MAX_STRIDE_DEF    = 16;
	localparam int HISTORY_DEPTH_DEF = 512;

	localparam logic [TAP_COUNT_BITS-1:0] TAP_COUNT_RESET = TAP_COUNT_BITS'(32);
	localparam logic [STRIDE_BITS-1:0]    STRIDE_RESET    = STRIDE_BITS'(1);

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_TAP_COUNT = 1'b0,
		REG_STRIDE    = 1'b1
	} reg_index_t;

	typedef enum logic [0:0] {
		CMD_FILTER = 1'b0,
		CMD_COEF   = 1'b1
	} item_cmd_t;

	typedef struct packed {
		item_cmd_t                          cmd;
		logic signed [SAMPLE_BITS-1:0]      sample_value;
		logic        [COEF_INDEX_BITS-1:0]  coef_index;
		logic signed [COEF_BITS-1:0]        coef_value;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] filtered_sample;
		logic                          saturated;
	} out_item_t;

	typedef struct packed {
		logic clear;
		logic take_sample;
		logic take_coef;
		logic setup;
		logic reduce;
		logic write;
		logic issue;
		logic load_out;
	} ctl_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic reduce_done;
		logic last_tap;
		logic pipe_busy;
		logic out_free;
	} dp_status_t;

endpackage

// File: rtl/sfir_ram.sv
module sfir_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/sfir_ctrl.sv
module sfir_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  sfir_pkg::item_cmd_t   in_cmd,
	output logic                  in_ready,
	input  sfir_pkg::dp_status_t  sts,
	output sfir_pkg::ctl_cmd_t    ctl
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SETUP,
		ST_REDUCE,
		ST_WRITE,
		ST_MAC,
		ST_DRAIN
	} state_t;

	state_t state_q;

	always_comb begin
		ctl             = '0;
		ctl.clear       = (state_q == ST_CLEAR);
		ctl.take_sample = (state_q == ST_IDLE) && in_valid && (in_cmd == sfir_pkg::CMD_FILTER);
		ctl.take_coef   = (state_q == ST_IDLE) && in_valid && (in_cmd == sfir_pkg::CMD_COEF);
		ctl.setup       = (state_q == ST_SETUP);
		ctl.reduce      = (state_q == ST_REDUCE);
		ctl.write       = (state_q == ST_WRITE);
		ctl.issue       = (state_q == ST_MAC);
		ctl.load_out    = (state_q == ST_DRAIN) && !sts.pipe_busy && sts.out_free;
	end

	assign in_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (sts.clear_done) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (ctl.take_sample) state_q <= ST_SETUP;
				end
				ST_SETUP: begin
					state_q <= ST_REDUCE;
				end
				ST_REDUCE: begin
					if (sts.reduce_done) state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					state_q <= ST_MAC;
				end
				ST_MAC: begin
					if (sts.last_tap) state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (ctl.load_out) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

endmodule

// File: rtl/sfir_dp.sv
module sfir_dp #(
	parameter int MAX_TAPS      = sfir_pkg::MAX_TAPS_DEF,
	parameter int MAX_STRIDE    = sfir_pkg::MAX_STRIDE_DEF,
	parameter int HISTORY_DEPTH = sfir_pkg::HISTORY_DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  sfir_pkg::in_item_t                   in_data,
	input  logic                                 out_ready,
	output logic                                 out_valid,
	output sfir_pkg::out_item_t                  out_data,
	input  logic                                 cfg_we,
	input  logic [sfir_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [sfir_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	input  sfir_pkg::ctl_cmd_t                   ctl,
	output sfir_pkg::dp_status_t                 sts
);

	localparam int SB    = sfir_pkg::SAMPLE_BITS;
	localparam int CB    = sfir_pkg::COEF_BITS;
	localparam int TW    = $clog2(MAX_TAPS + 1);
	localparam int SW    = $clog2(MAX_STRIDE + 1);
	localparam int JW    = $clog2(MAX_TAPS);
	localparam int AW    = $clog2(HISTORY_DEPTH);
	localparam int LW    = $clog2(HISTORY_DEPTH + 1);
	localparam int PW    = TW + SW;
	localparam int MW    = (SW > LW) ? SW : LW;
	localparam int KW    = ((MW > AW) ? MW : AW) + 1;
	localparam int CLR_N = (HISTORY_DEPTH > MAX_TAPS) ? HISTORY_DEPTH : MAX_TAPS;
	localparam int CLW   = $clog2(CLR_N);
	localparam int PRW   = SB + CB;
	localparam int ACC_W = PRW + $clog2(MAX_TAPS);

	localparam logic signed [ACC_W:0] RND_ADD = (ACC_W+1)'(1) <<< (sfir_pkg::FRAC_SHIFT - 1);
	localparam logic signed [ACC_W:0] Y_MAX   = (ACC_W+1)'(2**(SB-1) - 1);
	localparam logic signed [ACC_W:0] Y_MIN   = ~Y_MAX;

	logic [sfir_pkg::TAP_COUNT_BITS-1:0] tap_count_q;
	logic [sfir_pkg::STRIDE_BITS-1:0]    stride_q;
	logic [AW-1:0]                       wpos_q;
	logic signed [SB-1:0]                sample_q;
	logic [TW-1:0]                       taps_q;
	logic [SW-1:0]                       s_red_q;
	logic [LW-1:0]                       len_q;
	logic [AW-1:0]                       k_q;
	logic [JW-1:0]                       j_q;
	logic [CLW-1:0]                      clr_q;
	logic                                valid_s1;
	logic                                valid_s2;
	logic signed [PRW-1:0]               prod_s2;
	logic signed [ACC_W-1:0]             acc_q;
	logic                                out_valid_q;
	sfir_pkg::out_item_t                 out_q;

	logic [TW-1:0]        taps_c;
	logic [SW-1:0]        s_c;
	logic [PW-1:0]        len_full;
	logic [LW-1:0]        len_d;
	logic [AW-1:0]        pos;
	logic [AW-1:0]        pos_next;
	logic [AW-1:0]        k_next;
	logic                 hist_we;
	logic [AW-1:0]        hist_waddr;
	logic [SB-1:0]        hist_wdata;
	logic [SB-1:0]        hist_rdata;
	logic                 coef_we;
	logic [JW-1:0]        coef_waddr;
	logic [CB-1:0]        coef_wdata;
	logic [CB-1:0]        coef_rdata;
	logic signed [ACC_W:0] acc_ext;
	logic signed [ACC_W:0] rsum;
	logic signed [ACC_W:0] y;

	always_comb begin
		if (tap_count_q == '0) begin
			taps_c = TW'(1);
		end else if (32'(tap_count_q) > MAX_TAPS) begin
			taps_c = TW'(MAX_TAPS);
		end else begin
			taps_c = TW'(tap_count_q);
		end
		if (stride_q == '0) begin
			s_c = SW'(1);
		end else if (32'(stride_q) > MAX_STRIDE) begin
			s_c = SW'(MAX_STRIDE);
		end else begin
			s_c = SW'(stride_q);
		end
		len_full = PW'(taps_c - TW'(1)) * PW'(s_c) + PW'(1);
		if (32'(len_full) > 32'(HISTORY_DEPTH)) begin
			len_d = LW'(HISTORY_DEPTH);
		end else begin
			len_d = LW'(len_full);
		end
	end

	always_comb begin
		pos = (KW'(wpos_q) >= KW'(len_q)) ? '0 : wpos_q;
		pos_next = (KW'(pos) + KW'(1) == KW'(len_q)) ? '0 : AW'(KW'(pos) + KW'(1));
		if (KW'(k_q) >= KW'(s_red_q)) begin
			k_next = AW'(KW'(k_q) - KW'(s_red_q));
		end else begin
			k_next = AW'(KW'(k_q) + KW'(len_q) - KW'(s_red_q));
		end
	end

	always_comb begin
		hist_we    = 1'b0;
		hist_waddr = pos;
		hist_wdata = sample_q;
		if (ctl.clear) begin
			hist_we    = (32'(clr_q) < HISTORY_DEPTH);
			hist_waddr = AW'(clr_q);
			hist_wdata = '0;
		end else if (ctl.write) begin
			hist_we = 1'b1;
		end
		coef_we    = 1'b0;
		coef_waddr = JW'(in_data.coef_index);
		coef_wdata = in_data.coef_value;
		if (ctl.clear) begin
			coef_we    = (32'(clr_q) < MAX_TAPS);
			coef_waddr = JW'(clr_q);
			coef_wdata = '0;
		end else if (ctl.take_coef) begin
			coef_we = (32'(in_data.coef_index) < MAX_TAPS);
		end
	end

	sfir_ram #(
		.WIDTH (SB),
		.DEPTH (HISTORY_DEPTH)
	) u_hist_ram (
		.clk   (clk),
		.we    (hist_we),
		.waddr (hist_waddr),
		.wdata (hist_wdata),
		.raddr (k_q),
		.rdata (hist_rdata)
	);

	sfir_ram #(
		.WIDTH (CB),
		.DEPTH (MAX_TAPS)
	) u_coef_ram (
		.clk   (clk),
		.we    (coef_we),
		.waddr (coef_waddr),
		.wdata (coef_wdata),
		.raddr (j_q),
		.rdata (coef_rdata)
	);

	always_comb begin
		acc_ext = (ACC_W+1)'(acc_q);
		rsum    = acc_ext + RND_ADD;
		y       = rsum >>> sfir_pkg::FRAC_SHIFT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= sfir_pkg::TAP_COUNT_RESET;
			stride_q    <= sfir_pkg::STRIDE_RESET;
			wpos_q      <= '0;
			clr_q       <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (sfir_pkg::reg_index_t'(cfg_index))
					sfir_pkg::REG_TAP_COUNT: tap_count_q <= cfg_data;
					sfir_pkg::REG_STRIDE:    stride_q <= sfir_pkg::STRIDE_BITS'(cfg_data);
					default: ;
				endcase
				wpos_q <= '0;
			end else if (ctl.write) begin
				wpos_q <= pos_next;
			end
			if (ctl.clear) begin
				clr_q <= clr_q + CLW'(1);
			end
			valid_s1 <= ctl.issue;
			valid_s2 <= valid_s1;
			if (ctl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take_sample) begin
			sample_q <= in_data.sample_value;
		end
		if (ctl.setup) begin
			taps_q  <= taps_c;
			s_red_q <= s_c;
			len_q   <= len_d;
		end
		if (ctl.reduce && !sts.reduce_done) begin
			s_red_q <= SW'(MW'(s_red_q) - MW'(len_q));
		end
		if (ctl.write) begin
			k_q   <= pos;
			j_q   <= '0;
			acc_q <= '0;
		end else begin
			if (ctl.issue) begin
				k_q <= k_next;
				j_q <= j_q + JW'(1);
			end
			if (valid_s2) begin
				acc_q <= acc_q + ACC_W'(prod_s2);
			end
		end
		if (valid_s1) begin
			prod_s2 <= $signed(hist_rdata) * $signed(coef_rdata);
		end
		if (ctl.load_out) begin
			if (y > Y_MAX) begin
				out_q.filtered_sample <= SB'(Y_MAX);
				out_q.saturated       <= 1'b1;
			end else if (y < Y_MIN) begin
				out_q.filtered_sample <= SB'(Y_MIN);
				out_q.saturated       <= 1'b1;
			end else begin
				out_q.filtered_sample <= SB'(y);
				out_q.saturated       <= 1'b0;
			end
		end
	end

	always_comb begin
		sts.clear_done  = (32'(clr_q) == CLR_N - 1);
		sts.reduce_done = (MW'(s_red_q) < MW'(len_q));
		sts.last_tap    = (TW'(j_q) == taps_q - TW'(1));
		sts.pipe_busy   = valid_s1 || valid_s2;
		sts.out_free    = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// File: rtl/strided_fir_filter.sv
// channel   signals                       payload / notes
// in        in_valid, in_ready, in_data   in_item_t: cmd, sample, coef index and value
// out       out_valid, out_ready, out_data out_item_t: filtered_sample, saturated
// cfg       cfg_we, cfg_index, cfg_data   0 = tap_count, 1 = stride, no read-back
//
// A coefficient item is written to the coefficient RAM as it transfers; the controller stays idle.
// A sample item passes setup, reduction steps while stride is not below the history length,
// the history write, one multiply-accumulate issue per tap in use and a drain until its result
// is loaded; no new item transfers before then. One shared multiply-accumulate reads the history
// RAM once per tap. The drain holds while the output register is still full.
// After reset a clearing pass over max(HISTORY_DEPTH, MAX_TAPS) addresses zeroes both RAMs.
// A finished result waits in the output register; the next item is taken meanwhile.
module strided_fir_filter #(
	parameter int MAX_TAPS      = sfir_pkg::MAX_TAPS_DEF,
	parameter int MAX_STRIDE    = sfir_pkg::MAX_STRIDE_DEF,
	parameter int HISTORY_DEPTH = sfir_pkg::HISTORY_DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  sfir_pkg::in_item_t                   in_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output sfir_pkg::out_item_t                  out_data,
	input  logic                                 cfg_we,
	input  logic [sfir_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [sfir_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

	sfir_pkg::ctl_cmd_t   ctl;
	sfir_pkg::dp_status_t sts;

	sfir_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_cmd   (in_data.cmd),
		.in_ready (in_ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	sfir_dp #(
		.MAX_TAPS      (MAX_TAPS),
		.MAX_STRIDE    (MAX_STRIDE),
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ctl       (ctl),
		.sts       (sts)
	);

endmodule
